### hdl/urx_pkg.sv
// ----------------------------------------------------------------------------
// urx_pkg: shared types for the 8N1 serial receiver with receive FIFO
// Holds the channel item structs and the internal operation codes that pass
// from the frame decoder to the FIFO stage.
// ----------------------------------------------------------------------------
package urx_pkg;

    typedef struct packed {
        logic func;
        logic line_level;
    } urx_in_item_t;

    typedef struct packed {
        logic [7:0] popped_byte;
        logic       pop_valid;
        logic       data_available;
        logic       byte_stored;
        logic       framing_drop;
        logic       overflow_drop;
    } urx_out_item_t;

    // Register indexes on the configuration port.
    localparam logic CFG_BIT_PERIOD   = 1'b0;
    localparam logic CFG_FIRST_SAMPLE = 1'b1;

    // Operations handed from the frame decoder to the FIFO stage.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_STORE   = 2'd2;
    localparam logic [1:0] OP_FRAMING = 2'd3;

    typedef struct packed {
        logic [1:0] code;
        logic [7:0] data;
    } urx_op_t;

endpackage

### hdl/uart_rx_8n1_with_fifo_top.sv
// ----------------------------------------------------------------------------
// uart_rx_8n1_with_fifo_top: 8N1 serial receiver with receive FIFO
// Decodes serial frames from a stream of tick items and buffers good bytes
// in a ring FIFO that pop items drain.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                               Carries
//   -------  ----------------------------------  ------------------------------
//   input    s_valid, s_ready, s_item            tick with line level, or pop
//   result   m_valid, m_ready, m_item            one result item per input item
//   config   cfg_we, cfg_index, cfg_wdata        timing register writes
//
// The block accepts one item in every clock cycle while s_ready is high. An
// item is decoded in the cycle it is accepted, is registered in the queue, is
// executed against the FIFO, and its result is held in the result register.
// Reset is synchronous and active low; it clears the frame state and the FIFO
// pointers, while the FIFO storage itself is left as it is.
// A stalled result register holds; the two-entry queue absorbs the decoder's
// output, and s_ready drops only when that queue is full.
//
module uart_rx_8n1_with_fifo_top #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  urx_pkg::urx_in_item_t  s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output urx_pkg::urx_out_item_t m_item
);
    import urx_pkg::*;

    // Operation stream from the frame decoder into the queue.
    logic    dec_valid, dec_ready;
    urx_op_t dec_op;

    // Operation stream from the queue into the FIFO stage.
    logic    exe_valid, exe_ready;
    urx_op_t exe_op;

    // The decoder owns the timing registers, the bit counter, the shift
    // register and the previous line level. None of that depends on the FIFO,
    // so it can run ahead of the FIFO stage.
    urx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .op_valid  (dec_valid),
        .op_ready  (dec_ready),
        .op        (dec_op)
    );

    urx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (dec_valid),
        .push_ready (dec_ready),
        .push_op    (dec_op),
        .pop_valid  (exe_valid),
        .pop_ready  (exe_ready),
        .pop_op     (exe_op)
    );

    // The FIFO stage stores or drops completed bytes, serves pops, and keeps
    // one slot empty so that full and empty are told apart by the pointers.
    urx_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (exe_valid),
        .op_ready (exe_ready),
        .op       (exe_op),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

### hdl/urx_ram.sv
// ----------------------------------------------------------------------------
// urx_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module urx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/urx_front.sv
// ----------------------------------------------------------------------------
// urx_front: frame decoder
// Holds the timing registers and the per-frame state. Each accepted item is
// classified and turned into one operation for the FIFO stage.
// ----------------------------------------------------------------------------
module urx_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  urx_pkg::urx_in_item_t  s_item,
    output logic                   op_valid,
    input  logic                   op_ready,
    output urx_pkg::urx_op_t       op
);
    import urx_pkg::*;

    localparam logic [3:0] PHASE_IDLE       = 4'd0;
    localparam logic [3:0] PHASE_FIRST      = 4'd1;
    localparam logic [3:0] PHASE_STOP       = 4'd9;

    logic [7:0] bit_period_reg;
    logic [7:0] first_sample_reg;
    logic [3:0] phase_reg,  phase_next;
    logic [7:0] shift_reg,  shift_next;
    logic [7:0] count_reg,  count_next;
    logic       prev_reg,   prev_next;
    logic       accept;

    assign s_ready  = op_ready;
    assign op_valid = s_valid;
    assign accept   = s_valid & op_ready;

    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        op.code    = OP_TICK;
        op.data    = shift_reg;
        if (s_item.func) begin
            op.code = OP_POP;
        end else if (phase_reg == PHASE_IDLE) begin
            if (prev_reg && !s_item.line_level) begin
                phase_next = PHASE_FIRST;
                shift_next = '0;
                count_next = first_sample_reg;
            end
            prev_next = s_item.line_level;
        end else begin
            if (count_reg <= 8'd1) begin
                count_next = bit_period_reg;
                if (phase_reg < PHASE_STOP) begin
                    shift_next = {s_item.line_level, shift_reg[7:1]};
                    phase_next = phase_reg + 4'd1;
                end else begin
                    op.code    = s_item.line_level ? OP_STORE : OP_FRAMING;
                    phase_next = PHASE_IDLE;
                end
            end else begin
                count_next = count_reg - 8'd1;
            end
            prev_next = s_item.line_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg   <= 8'd104;
            first_sample_reg <= 8'd156;
            phase_reg        <= PHASE_IDLE;
            shift_reg        <= '0;
            count_reg        <= '0;
            prev_reg         <= 1'b1;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BIT_PERIOD:   bit_period_reg   <= cfg_wdata;
                    CFG_FIRST_SAMPLE: first_sample_reg <= cfg_wdata;
                    default:          bit_period_reg   <= bit_period_reg;
                endcase
            end
            if (accept) begin
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                count_reg <= count_next;
                prev_reg  <= prev_next;
            end
        end
    end

endmodule

### hdl/urx_queue.sv
// ----------------------------------------------------------------------------
// urx_queue: two-entry operation queue
// Separates the frame decoder from the FIFO stage so each can stall alone.
// ----------------------------------------------------------------------------
module urx_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  urx_pkg::urx_op_t push_op,
    output logic             pop_valid,
    input  logic             pop_ready,
    output urx_pkg::urx_op_t pop_op
);
    import urx_pkg::*;

    urx_op_t    slot_reg [2];
    logic [1:0] count_reg;
    logic       wr_reg;
    logic       rd_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = slot_reg[rd_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end else begin
            if (do_push) begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop) begin
                rd_reg <= ~rd_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### hdl/urx_back.sv
// ----------------------------------------------------------------------------
// urx_back: receive FIFO and result stage
// Executes one operation per cycle, unless the result stalls, on the FIFO
// and registers the result item; the popped byte is a registered RAM read.
// ----------------------------------------------------------------------------
module urx_back #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   op_valid,
    output logic                   op_ready,
    input  urx_pkg::urx_op_t       op,
    output logic                   m_valid,
    input  logic                   m_ready,
    output urx_pkg::urx_out_item_t m_item
);
    import urx_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        ptr_next = (p == LAST) ? '0 : p + AW'(1);
    endfunction

    logic [AW-1:0] wp_reg, rp_reg, wp_inc, wp_new, rp_new;
    logic          out_valid_reg;
    logic          pop_valid_reg, avail_reg, stored_reg, fdrop_reg, odrop_reg;
    logic          advance, take;
    logic          pop_ok, store_ok, odrop, fdrop, full;
    logic [7:0]    rdata;

    assign advance  = !out_valid_reg || m_ready;
    assign op_ready = advance;
    assign take     = advance & op_valid;

    assign wp_inc   = ptr_next(wp_reg);
    assign full     = (wp_inc == rp_reg);
    assign pop_ok   = (op.code == OP_POP) && (rp_reg != wp_reg);
    assign store_ok = (op.code == OP_STORE) && !full;
    assign odrop    = (op.code == OP_STORE) && full;
    assign fdrop    = (op.code == OP_FRAMING);
    assign rp_new   = pop_ok ? ptr_next(rp_reg) : rp_reg;
    assign wp_new   = store_ok ? wp_inc : wp_reg;

    urx_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (take & store_ok),
        .waddr (wp_reg),
        .wdata (op.data),
        .re    (take & pop_ok),
        .raddr (rp_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (take) begin
            pop_valid_reg <= pop_ok;
            avail_reg     <= (rp_new != wp_new);
            stored_reg    <= store_ok;
            fdrop_reg     <= fdrop;
            odrop_reg     <= odrop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= op_valid;
            end
            if (take) begin
                wp_reg <= wp_new;
                rp_reg <= rp_new;
            end
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_item.popped_byte    = pop_valid_reg ? rdata : 8'd0;
    assign m_item.pop_valid      = pop_valid_reg;
    assign m_item.data_available = avail_reg;
    assign m_item.byte_stored    = stored_reg;
    assign m_item.framing_drop   = fdrop_reg;
    assign m_item.overflow_drop  = odrop_reg;

endmodule
